// ----- rtl/esc_pkg.sv -----
// shared types, constants and table functions for the extremum seeking controller
package esc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PcW      = 4;
  localparam int unsigned SineW    = 16;
  localparam int unsigned MulBW    = 25;

  localparam logic [CfgIdxW-1:0] CFG_HPF_COEF     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LPF_COEF     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PHASE_STEP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_GAIN    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DITHER_AMP   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SEEK_MINIMUM = 3'd5;

  localparam logic [PcW-1:0] ST_IDLE  = 4'd0;
  localparam logic [PcW-1:0] ST_SINE  = 4'd1;
  localparam logic [PcW-1:0] ST_HP    = 4'd2;
  localparam logic [PcW-1:0] ST_DITH  = 4'd3;
  localparam logic [PcW-1:0] ST_ERR   = 4'd4;
  localparam logic [PcW-1:0] ST_LPMUL = 4'd5;
  localparam logic [PcW-1:0] ST_GRAD  = 4'd6;
  localparam logic [PcW-1:0] ST_GMUL  = 4'd7;
  localparam logic [PcW-1:0] ST_THETA = 4'd8;
  localparam logic [PcW-1:0] ST_OUT   = 4'd9;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef enum logic [2:0] {
    A_D,
    A_AMP,
    A_HP,
    A_ERR,
    A_GRAD
  } a_sel_e;

  typedef enum logic [1:0] {
    B_HPF,
    B_SINE,
    B_LPF,
    B_GAIN
  } b_sel_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_LOAD,
    WB_SINE,
    WB_HP,
    WB_DITH,
    WB_ERR,
    WB_GRAD,
    WB_THETA,
    WB_OUT
  } wb_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_REQ,
    HOLD_OUT
  } hold_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    wb_e    wb;
    hold_e  hold;
    logic   restart;
  } uword_t;

  // control store
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      ST_IDLE:  w = '{A_D,    B_HPF,  WB_LOAD,  HOLD_REQ,  1'b0};
      ST_SINE:  w = '{A_D,    B_HPF,  WB_SINE,  HOLD_NONE, 1'b0};
      ST_HP:    w = '{A_AMP,  B_SINE, WB_HP,    HOLD_NONE, 1'b0};
      ST_DITH:  w = '{A_HP,   B_SINE, WB_DITH,  HOLD_NONE, 1'b0};
      ST_ERR:   w = '{A_ERR,  B_LPF,  WB_ERR,   HOLD_NONE, 1'b0};
      ST_LPMUL: w = '{A_ERR,  B_LPF,  WB_NONE,  HOLD_NONE, 1'b0};
      ST_GRAD:  w = '{A_GRAD, B_GAIN, WB_GRAD,  HOLD_NONE, 1'b0};
      ST_GMUL:  w = '{A_GRAD, B_GAIN, WB_NONE,  HOLD_NONE, 1'b0};
      ST_THETA: w = '{A_GRAD, B_GAIN, WB_THETA, HOLD_NONE, 1'b0};
      ST_OUT:   w = '{A_D,    B_HPF,  WB_OUT,   HOLD_OUT,  1'b1};
      default:  w = '{A_D,    B_HPF,  WB_NONE,  HOLD_NONE, 1'b1};
    endcase
    return w;
  endfunction

  // shift and subtract quotient for the table build
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int              i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter sine entry, unsigned Q0.15, evaluated at elaboration
  function automatic logic [SineW-2:0] sine_entry(int unsigned idx, int unsigned qbits);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    int unsigned     k;
    a = (HalfPiQ30 * longint'(2 * idx + 1) + (64'd1 << qbits)) >> (qbits + 1);
    a2 = (a * a) >> 30;
    term = a;
    sum = longint'(a);
    for (k = 1; k <= 12; k++) begin
      term = (term * a2) >> 30;
      term = udiv64(term, 64'((2 * k) * (2 * k + 1)));
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SineW-2:0];
  endfunction

endpackage

// ----- rtl/esc_sine.sv -----
// dither sine lookup from a quarter-wave table with registered output
module esc_sine #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [PHASE_BITS-1:0]       phase_i,
  output logic signed [esc_pkg::SineW-1:0] sine_o
);
  import esc_pkg::*;

  localparam int QBits = SINE_TABLE_BITS - 2;
  localparam int QLen  = 1 << QBits;

  logic [SineW-2:0]           rom [QLen];
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QBits-1:0]           addr;
  logic [SineW-1:0]           mag;
  logic signed [SineW-1:0]    sine_d;
  logic signed [SineW-1:0]    sine_q;

  for (genvar i = 0; i < QLen; i++) begin : g_rom
    localparam logic [SineW-2:0] Entry = sine_entry(i, QBits);
    assign rom[i] = Entry;
  end

  assign idx  = phase_i[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];

  always_comb begin
    addr = idx[QBits-1:0];
    if (quad[0]) begin
      addr = ~idx[QBits-1:0];
    end
    mag = {1'b0, rom[addr]};
    sine_d = quad[1] ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

// ----- rtl/extremum_seeking_controller.sv -----
// Top level of the perturbation extremum seeking controller. Every accepted cost
// sample gives one drive value. A ten-step microprogram runs each sample through
// the high-pass, demodulation, low-pass and integrator updates on a single shared
// multiplier (about 34 x 25 bits at the default sample width), one product per
// step. A sample is accepted in the idle step and its result is written to the
// output register in the last step before the sequencer returns to idle, so a new
// sample is taken only once the previous one is through. The result sits in an
// output register, so the next sample is accepted while it waits; the sequencer
// only stalls at its last step if that register is still full and not being read.
// Configuration writes are taken every cycle and belong between samples, while no
// sample is in flight.
module extremum_seeking_controller #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [esc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [esc_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   cost_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   drive_value_o,
  output logic                            clipped_o
);
  import esc_pkg::*;

  localparam int DW    = ((SAMPLE_BITS + 17 > 32) ? SAMPLE_BITS + 17 : 32) + 1;
  localparam int MulAW = DW;
  localparam int PW    = MulAW + MulBW;
  localparam int SumW  = 34;

  localparam logic signed [PW-1:0]   PMax = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0]   PMin = PW'(-64'sd2147483648);
  localparam logic signed [SumW-1:0] DHi  = SumW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0] DLo  = SumW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  function automatic logic signed [31:0] sat32(logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > PMax) begin
      r = 32'sh7fffffff;
    end else if (v < PMin) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic [15:0]           hpf_q;
  logic [15:0]           lpf_q;
  logic [31:0]           step_q;
  logic [23:0]           gain_q;
  logic [14:0]           amp_q;
  logic                  seek_min_q;

  // sequencer
  logic [PcW-1:0]        pc_q;
  logic [PcW-1:0]        pc_d;
  uword_t                uw;
  logic                  hold;

  // state and datapath
  logic [PHASE_BITS-1:0]         phase_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [31:0]            hp_q;
  logic signed [31:0]            g_q;
  logic signed [31:0]            theta_q;
  logic signed [DW-1:0]          d_q;
  logic signed [32:0]            e_q;
  logic signed [30:0]            dith_q;
  logic signed [PW-1:0]          p_q;
  logic signed [SineW-1:0]       sine;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [DW-1:0]          d_d;
  logic signed [MulAW-1:0]       mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [PW-1:0]          p_d;
  logic signed [PW-1:0]          p_sh16;
  logic signed [PW-1:0]          p_sh15;
  logic signed [PW-1:0]          g_sum;
  logic signed [PW-1:0]          theta_sum;
  logic signed [SumW-1:0]        out_sum;
  logic signed [SumW-1:0]        out_sh;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] drive_q;
  logic                          clip_q;
  logic                          out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpf_q      <= 16'hffff;
      lpf_q      <= 16'd655;
      step_q     <= 32'd42949673;
      gain_q     <= 24'd65536;
      amp_q      <= 15'd1024;
      seek_min_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HPF_COEF:     hpf_q      <= cfg_data_i[15:0];
        CFG_LPF_COEF:     lpf_q      <= cfg_data_i[15:0];
        CFG_PHASE_STEP:   step_q     <= cfg_data_i;
        CFG_STEP_GAIN:    gain_q     <= cfg_data_i[23:0];
        CFG_DITHER_AMP:   amp_q      <= cfg_data_i[14:0];
        CFG_SEEK_MINIMUM: seek_min_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // microcode fetch and next step
  assign uw       = ucode(pc_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (uw.hold)
      HOLD_REQ: hold = !in_valid_i;
      HOLD_OUT: hold = !out_free;
      default:  hold = 1'b0;
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (uw.restart) begin
      pc_d = ST_IDLE;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o = (pc_q == ST_IDLE);

  // shared multiplier
  always_comb begin
    case (uw.a_sel)
      A_D:     mul_a = d_q;
      A_AMP:   mul_a = MulAW'(amp_q);
      A_HP:    mul_a = MulAW'(hp_q);
      A_ERR:   mul_a = MulAW'(e_q);
      A_GRAD:  mul_a = MulAW'(g_q);
      default: mul_a = d_q;
    endcase
    case (uw.b_sel)
      B_HPF:   mul_b = MulBW'(hpf_q);
      B_SINE:  mul_b = MulBW'(sine);
      B_LPF:   mul_b = MulBW'(lpf_q);
      B_GAIN:  mul_b = MulBW'(gain_q);
      default: mul_b = MulBW'(hpf_q);
    endcase
  end

  assign p_d = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  esc_sine #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .en_i   (uw.wb == WB_SINE),
    .phase_i(phase_q),
    .sine_o (sine)
  );

  // write-back arithmetic
  assign diff      = (SAMPLE_BITS + 1)'(cost_sample_i) - (SAMPLE_BITS + 1)'(prev_q);
  assign d_d       = DW'(hp_q) + (DW'(diff) <<< 16);
  assign p_sh16    = p_q >>> 16;
  assign p_sh15    = p_q >>> 15;
  assign g_sum     = PW'(g_q) + p_sh16;
  assign theta_sum = seek_min_q ? PW'(theta_q) - p_sh16 : PW'(theta_q) + p_sh16;
  assign out_sum   = SumW'(theta_q) + (SumW'(dith_q) <<< 1) + SumW'(32768);
  assign out_sh    = out_sum >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      prev_q  <= '0;
      hp_q    <= '0;
      g_q     <= '0;
      theta_q <= '0;
    end else if (!hold) begin
      case (uw.wb)
        WB_LOAD: begin
          phase_q <= phase_q + PHASE_BITS'(step_q);
          prev_q  <= cost_sample_i;
        end
        WB_HP:    hp_q    <= sat32(p_sh16);
        WB_GRAD:  g_q     <= sat32(g_sum);
        WB_THETA: theta_q <= sat32(theta_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold) begin
      case (uw.wb)
        WB_LOAD: d_q    <= d_d;
        WB_DITH: dith_q <= p_q[30:0];
        WB_ERR:  e_q    <= 33'($signed(p_sh15[31:0])) - 33'(g_q);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.wb == WB_OUT && !hold) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.wb == WB_OUT && !hold) begin
      if (out_sh > DHi) begin
        drive_q <= DHi[SAMPLE_BITS-1:0];
        clip_q  <= 1'b1;
      end else if (out_sh < DLo) begin
        drive_q <= DLo[SAMPLE_BITS-1:0];
        clip_q  <= 1'b1;
      end else begin
        drive_q <= out_sh[SAMPLE_BITS-1:0];
        clip_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;
  assign clipped_o     = clip_q;

endmodule

// ----- rtl/esc_checker.sv -----
// port-level checks for the extremum seeking controller and their bind
module esc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [esc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [esc_pkg::CfgDataW-1:0]  cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic signed [SAMPLE_BITS-1:0] cost_sample_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] drive_value_o,
  input logic                          clipped_o
);

  localparam logic signed [SAMPLE_BITS-1:0] DMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] DMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a request starts the sequence, so the next one cannot follow at once
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // a result only appears at the end of a sequence, never straight from idle
  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a running sequence");

  // saturation flag only with a rail value
  a_clip_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> drive_value_o == DMax || drive_value_o == DMin)
    else $error("clip flag set off the rails");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o)
      && $stable(clipped_o))
    else $error("pending result changed");

endmodule

bind extremum_seeking_controller esc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_esc_checker (.*);
